// File: rtl/lsrd_pkg.sv
// Package with the constants, types and tables of the line sensor ring direction block.
`timescale 1ns / 1ps

package lsrd_pkg;

  localparam int SENSOR_COUNT  = 18;
  localparam int FRACTION_BITS = 14;
  localparam int LEVEL_W       = 18;
  localparam int BYTE_W        = 8;
  localparam int PRESCALE      = 20;
  localparam int CORDIC_STEPS  = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SENSOR_IDX_W  = $clog2(SENSOR_COUNT);
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  localparam int VEC_W         = FRACTION_BITS + 2;
  localparam int SUM_W         = FRACTION_BITS + $clog2(SENSOR_COUNT) + 2;
  localparam int CORDIC_W      = SUM_W + PRESCALE + 2;
  localparam int Z_W           = 25;
  localparam int Z_FRAC        = 16;

  localparam logic [5:0] RING_TENS    = 6'd36;
  localparam logic [5:0] QUARTER_TENS = 6'd9;
  localparam logic [5:0] HALF_TENS    = 6'd18;
  localparam logic [5:0] LAST_TENS    = 6'd27;

  localparam logic signed [Z_W-1:0] Z_RIGHT = Z_W'(90 * 65536);
  localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(180 * 65536);

  localparam logic [BYTE_W-1:0] DEG_ZERO  = 8'd0;
  localparam logic [BYTE_W-1:0] DEG_RIGHT = 8'd90;
  localparam logic [BYTE_W-1:0] DEG_HALF  = 8'd180;
  localparam logic [BYTE_W-1:0] NO_LINE   = 8'hFF;
  localparam logic [BYTE_W-1:0] FLAG_POS  = 8'h00;
  localparam logic [BYTE_W-1:0] FLAG_NEG  = 8'h01;

  localparam logic [BYTE_W-1:0] CMD_ID_FIRST   = 8'hF3;
  localparam logic [BYTE_W-1:0] CMD_ID_SECOND  = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_DIR_FIRST  = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_DIR_SECOND = 8'h33;

  localparam logic OPCODE_SAMPLE  = 1'b0;
  localparam logic OPCODE_COMMAND = 1'b1;

  typedef enum logic [1:0] {
    JOB_SAMPLE,
    JOB_ID,
    JOB_DIR
  } job_kind_t;

  typedef struct packed {
    job_kind_t            kind;
    logic [LEVEL_W-1:0]   levels;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SETUP,
    ST_CORDIC,
    ST_FINISH,
    ST_REPLY0,
    ST_REPLY1
  } back_state_t;

  function automatic logic [30:0] sin_q30(input logic [3:0] j);
    case (j)
      4'd0:    sin_q30 = 31'd0;
      4'd1:    sin_q30 = 31'd186453311;
      4'd2:    sin_q30 = 31'd367241333;
      4'd3:    sin_q30 = 31'd536870912;
      4'd4:    sin_q30 = 31'd690187940;
      4'd5:    sin_q30 = 31'd822533958;
      4'd6:    sin_q30 = 31'd929887697;
      4'd7:    sin_q30 = 31'd1008987269;
      4'd8:    sin_q30 = 31'd1057429273;
      4'd9:    sin_q30 = 31'd1073741824;
      default: sin_q30 = 31'd0;
    endcase
  endfunction

  // Sine of k times ten degrees, rounded half away from zero to FRACTION_BITS.
  function automatic logic signed [VEC_W-1:0] unit_sin(input logic [5:0] k);
    logic [3:0]  j;
    logic        neg;
    logic [30:0] rnd;
    if (k <= QUARTER_TENS) begin
      j = 4'(k);
      neg = 1'b0;
    end else if (k <= HALF_TENS) begin
      j = 4'(HALF_TENS - k);
      neg = 1'b0;
    end else if (k <= LAST_TENS) begin
      j = 4'(k - HALF_TENS);
      neg = 1'b1;
    end else begin
      j = 4'(RING_TENS - k);
      neg = 1'b1;
    end
    rnd = (sin_q30(j) + (31'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
    unit_sin = neg ? -VEC_W'(rnd) : VEC_W'(rnd);
  endfunction

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    case (32'(i))
      0:       atan_q16 = Z_W'(2949120);
      1:       atan_q16 = Z_W'(1740967);
      2:       atan_q16 = Z_W'(919879);
      3:       atan_q16 = Z_W'(466945);
      4:       atan_q16 = Z_W'(234379);
      5:       atan_q16 = Z_W'(117304);
      6:       atan_q16 = Z_W'(58666);
      7:       atan_q16 = Z_W'(29335);
      8:       atan_q16 = Z_W'(14668);
      9:       atan_q16 = Z_W'(7334);
      10:      atan_q16 = Z_W'(3667);
      11:      atan_q16 = Z_W'(1833);
      12:      atan_q16 = Z_W'(917);
      13:      atan_q16 = Z_W'(458);
      14:      atan_q16 = Z_W'(229);
      15:      atan_q16 = Z_W'(115);
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

// File: rtl/lsrd_if.sv
// Channel interfaces for host commands and sensor samples in, and reply bytes out.
`timescale 1ns / 1ps

interface lsrd_cmd_if;
  import lsrd_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [LEVEL_W-1:0] sensor_levels;
  logic [BYTE_W-1:0]  command_first;
  logic [BYTE_W-1:0]  command_second;

  modport source (output valid, opcode, sensor_levels, command_first, command_second,
                  input ready);
  modport sink (input valid, opcode, sensor_levels, command_first, command_second,
                output ready);
endinterface

interface lsrd_reply_if;
  import lsrd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] reply_byte;
  logic              reply_last;

  modport source (output valid, reply_byte, reply_last, input ready);
  modport sink (input valid, reply_byte, reply_last, output ready);
endinterface

// File: rtl/lsrd_front.sv
// Front end that takes input transfers, decodes them and queues the jobs that need work.
`timescale 1ns / 1ps

module lsrd_front (
  lsrd_cmd_if.sink        cmd,
  input  logic            full,
  output logic            push,
  output lsrd_pkg::job_t  push_job
);
  import lsrd_pkg::*;

  logic is_id;
  logic is_dir;

  assign cmd.ready = ~full;
  assign is_id  = (cmd.command_first == CMD_ID_FIRST) && (cmd.command_second == CMD_ID_SECOND);
  assign is_dir = (cmd.command_first == CMD_DIR_FIRST) && (cmd.command_second == CMD_DIR_SECOND);

  // Unknown commands are taken and dropped here.
  always_comb begin
    push_job.levels = cmd.sensor_levels;
    push_job.kind   = JOB_SAMPLE;
    push            = 1'b0;
    if (cmd.valid && !full) begin
      if (cmd.opcode == OPCODE_SAMPLE) begin
        push = 1'b1;
      end else if (is_id) begin
        push_job.kind = JOB_ID;
        push = 1'b1;
      end else if (is_dir) begin
        push_job.kind = JOB_DIR;
        push = 1'b1;
      end
    end
  end

endmodule

// File: rtl/lsrd_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module lsrd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lsrd_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output lsrd_pkg::job_t  pop_job,
  output logic            not_empty
);
  import lsrd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lsrd_back.sv
// Back end that sums sensor vectors, runs the CORDIC angle search and sends replies.
`timescale 1ns / 1ps

module lsrd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  lsrd_pkg::job_t  job,
  output logic            pop,
  lsrd_reply_if.source    reply
);
  import lsrd_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [LEVEL_W-1:0]      job_levels;
  logic [SENSOR_COUNT-1:0] levels_ext;
  logic [SENSOR_IDX_W-1:0] sensor_idx;
  logic [STEP_W-1:0]       step;

  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [SUM_W-1:0]    abs_x;
  logic signed [SUM_W-1:0]    abs_y;
  logic signed [CORDIC_W-1:0] cx;
  logic signed [CORDIC_W-1:0] cy;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [Z_W-1:0]      cz;
  logic signed [Z_W-1:0]      z_clamp;
  logic signed [Z_W-1:0]      z_final;

  logic [5:0] twice;
  logic [5:0] k_sin;
  logic [5:0] k_cos;
  logic       active;

  logic [BYTE_W-1:0] dir_flag;
  logic [BYTE_W-1:0] dir_deg;
  logic [BYTE_W-1:0] reply_first;
  logic [BYTE_W-1:0] reply_second;
  logic              out_load;

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_ext
    if (g < LEVEL_W) begin : g_in
      assign levels_ext[g] = job_levels[g];
    end else begin : g_pad
      assign levels_ext[g] = 1'b0;
    end
  end

  assign active = ~levels_ext[sensor_idx];
  assign twice  = 6'(sensor_idx) << 1;
  assign k_sin  = (twice >= RING_TENS) ? twice - RING_TENS : twice;
  assign k_cos  = (k_sin >= LAST_TENS) ? k_sin - LAST_TENS : k_sin + QUARTER_TENS;

  assign abs_x = sum_x[SUM_W-1] ? -sum_x : sum_x;
  assign abs_y = sum_y[SUM_W-1] ? -sum_y : sum_y;
  assign dx    = cy >>> step;
  assign dy    = cx >>> step;

  always_comb begin
    if (cz[Z_W-1]) begin
      z_clamp = '0;
    end else if (cz > Z_RIGHT) begin
      z_clamp = Z_RIGHT;
    end else begin
      z_clamp = cz;
    end
    z_final = sum_x[SUM_W-1] ? Z_HALF - z_clamp : z_clamp;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          state_next = (job.kind == JOB_SAMPLE) ? ST_ACCUM : ST_REPLY0;
        end
      end
      ST_ACCUM: begin
        if (sensor_idx == SENSOR_IDX_W'(SENSOR_COUNT - 1)) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (abs_x != '0 && abs_y != '0) begin
          state_next = ST_CORDIC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CORDIC: begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      ST_REPLY0: begin
        if (out_load) begin
          state_next = ST_REPLY1;
        end
      end
      ST_REPLY1: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:   pop = job_valid;
      ST_REPLY0: out_load = ~reply.valid | reply.ready;
      ST_REPLY1: out_load = ~reply.valid | reply.ready;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_flag    <= NO_LINE;
      dir_deg     <= NO_LINE;
      reply.valid <= 1'b0;
    end else begin
      if (out_load) begin
        reply.valid <= 1'b1;
      end else if (reply.ready) begin
        reply.valid <= 1'b0;
      end
      if (state == ST_SETUP) begin
        if (abs_x == '0 && abs_y == '0) begin
          dir_flag <= NO_LINE;
          dir_deg  <= NO_LINE;
        end else if (abs_y == '0) begin
          dir_flag <= FLAG_POS;
          dir_deg  <= sum_x[SUM_W-1] ? DEG_HALF : DEG_ZERO;
        end else if (abs_x == '0) begin
          dir_flag <= sum_y[SUM_W-1] ? FLAG_NEG : FLAG_POS;
          dir_deg  <= DEG_RIGHT;
        end
      end
      if (state == ST_FINISH) begin
        dir_deg  <= z_final[Z_FRAC +: BYTE_W];
        dir_flag <= (sum_y[SUM_W-1] && z_final[Z_FRAC +: BYTE_W] != DEG_ZERO) ?
                    FLAG_NEG : FLAG_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job_levels <= job.levels;
        sensor_idx <= '0;
        sum_x      <= '0;
        sum_y      <= '0;
        if (job.kind == JOB_ID) begin
          reply_first  <= CMD_ID_FIRST;
          reply_second <= CMD_ID_SECOND;
        end else begin
          reply_first  <= dir_flag;
          reply_second <= dir_deg;
        end
      end
      ST_ACCUM: begin
        sensor_idx <= sensor_idx + 1'b1;
        if (active) begin
          sum_x <= sum_x + SUM_W'(unit_sin(k_cos));
          sum_y <= sum_y + SUM_W'(unit_sin(k_sin));
        end
      end
      ST_SETUP: begin
        cx   <= CORDIC_W'(abs_x) <<< PRESCALE;
        cy   <= CORDIC_W'(abs_y) <<< PRESCALE;
        cz   <= '0;
        step <= '0;
      end
      ST_CORDIC: begin
        step <= step + 1'b1;
        if (!cy[CORDIC_W-1]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_q16(step);
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_q16(step);
        end
      end
      ST_REPLY0: begin
        if (out_load) begin
          reply.reply_byte <= reply_first;
          reply.reply_last <= 1'b0;
        end
      end
      ST_REPLY1: begin
        if (out_load) begin
          reply.reply_byte <= reply_second;
          reply.reply_last <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_reply_pair: assert property (@(posedge clk) disable iff (rst)
    reply.valid && !reply.reply_last |=> reply.valid)
    else $error("First reply byte was not followed by the final byte.");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE)
    else $error("Job taken from the queue while the back end was busy.");

  a_cordic_x: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORDIC |-> !cx[CORDIC_W-1])
    else $error("CORDIC x component went negative.");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    (dir_deg <= DEG_HALF && (dir_flag == FLAG_POS || dir_flag == FLAG_NEG)) ||
    (dir_flag == NO_LINE && dir_deg == NO_LINE))
    else $error("Stored direction is out of range.");
`endif

endmodule

// File: rtl/line_sensor_ring_direction_core.sv
// Top level of the line sensor ring direction block.
//
// The cmd channel carries sensor samples (opcode 0) and two-byte host
// commands (opcode 1). A sample updates the stored direction and sends
// nothing. Command F3 03 answers the ID bytes F3, 03; command F0 33 answers
// the stored sign flag and degree bytes; other commands are dropped.
// The reply channel sends one byte per transfer, reply_last on the second.
// A sample has the back end add one sensor vector per cycle, then, when
// neither sum is zero, run the CORDIC angle search at one step per cycle.
// A command moves the back end from idle through its two reply states,
// one per reply byte, each of which waits while reply stalls.
// A two-entry job queue lets cmd transfers continue while the back end
// works; when reply stalls, the held byte stays and the queue fills.
// Reset stores the no-line value FF, FF and empties the queue.
`timescale 1ns / 1ps

module line_sensor_ring_direction_core (
  input  logic          clk,
  input  logic          rst,
  lsrd_cmd_if.sink      cmd,
  lsrd_reply_if.source  reply
);
  import lsrd_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic not_empty;
  job_t push_job;
  job_t pop_job;

  lsrd_front u_front (
    .cmd      (cmd),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  lsrd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (not_empty)
  );

  lsrd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (not_empty),
    .job       (pop_job),
    .pop       (pop),
    .reply     (reply)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the line sensor ring direction block.
`timescale 1ns / 1ps

module tb_top;
  import lsrd_pkg::*;

  localparam int RUN_LIMIT   = 1000000;
  localparam int DRAIN_WAIT  = 80;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 40;
  localparam int PHASE_ITEMS = 450;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } due_byte_t;

  class reply_checker;
    due_byte_t         bytes_due[$];
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] degree_byte;
    int                errors;
    int                transfers_in;

    function new();
      flag_byte    = NO_LINE;
      degree_byte  = NO_LINE;
      errors       = 0;
      transfers_in = 0;
    endfunction

    function longint sine_base_q30(int j);
      case (j)
        0:       return 0;
        1:       return 186453311;
        2:       return 367241333;
        3:       return 536870912;
        4:       return 690187940;
        5:       return 822533958;
        6:       return 929887697;
        7:       return 1008987269;
        8:       return 1057429273;
        default: return 1073741824;
      endcase
    endfunction

    function longint atan_step_q16(int i);
      case (i)
        0:       return 2949120;
        1:       return 1740967;
        2:       return 919879;
        3:       return 466945;
        4:       return 234379;
        5:       return 117304;
        6:       return 58666;
        7:       return 29335;
        8:       return 14668;
        9:       return 7334;
        10:      return 3667;
        11:      return 1833;
        12:      return 917;
        13:      return 458;
        14:      return 229;
        default: return 115;
      endcase
    endfunction

    // Sine of k times ten degrees, rounded half away from zero.
    function longint unit_component(int k);
      longint t;
      longint mag;
      longint r;
      k = k % 36;
      if (k <= 9) t = sine_base_q30(k);
      else if (k <= 18) t = sine_base_q30(18 - k);
      else if (k <= 27) t = -sine_base_q30(k - 18);
      else t = -sine_base_q30(36 - k);
      mag = (t < 0) ? -t : t;
      r = (mag + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
      return (t < 0) ? -r : r;
    endfunction

    function longint vector_angle_q16(longint ax, longint ay);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = ax <<< PRESCALE;
      y = ay <<< PRESCALE;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_step_q16(i);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_step_q16(i);
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return z;
    endfunction

    function void predict_direction(logic [LEVEL_W-1:0] levels);
      longint sum_x;
      longint sum_y;
      longint mag_x;
      longint mag_y;
      longint z;
      int     deg;
      sum_x = 0;
      sum_y = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (!levels[i]) begin
          sum_x = sum_x + unit_component((2 * i) % 36 + 9);
          sum_y = sum_y + unit_component((2 * i) % 36);
        end
      end
      if (sum_x == 0 && sum_y == 0) begin
        flag_byte   = NO_LINE;
        degree_byte = NO_LINE;
        return;
      end
      mag_x = (sum_x < 0) ? -sum_x : sum_x;
      mag_y = (sum_y < 0) ? -sum_y : sum_y;
      if (mag_y == 0) begin
        deg = (sum_x > 0) ? int'(DEG_ZERO) : int'(DEG_HALF);
      end else if (mag_x == 0) begin
        deg = int'(DEG_RIGHT);
      end else begin
        z = vector_angle_q16(mag_x, mag_y);
        if (sum_x < 0) z = 180 * 65536 - z;
        deg = int'(z >>> 16);
      end
      flag_byte   = (sum_y < 0 && deg != 0) ? FLAG_NEG : FLAG_POS;
      degree_byte = BYTE_W'(deg);
    endfunction

    function void push_pair(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
      bytes_due.push_back('{value: a, last: 1'b0});
      bytes_due.push_back('{value: b, last: 1'b1});
    endfunction

    function void note_transfer(logic op, logic [LEVEL_W-1:0] levels,
                                logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second);
      transfers_in++;
      if (op == OPCODE_SAMPLE) begin
        predict_direction(levels);
      end else if (first == CMD_ID_FIRST && second == CMD_ID_SECOND) begin
        push_pair(CMD_ID_FIRST, CMD_ID_SECOND);
      end else if (first == CMD_DIR_FIRST && second == CMD_DIR_SECOND) begin
        push_pair(flag_byte, degree_byte);
      end
    endfunction

    function void check_reply(logic [BYTE_W-1:0] value, logic last);
      due_byte_t due;
      if (bytes_due.size() == 0) begin
        $display("%0t: reply byte with none expected: expected nothing, actual %02h last %0b",
                 $time, value, last);
        errors++;
        return;
      end
      due = bytes_due.pop_front();
      if (value !== due.value) begin
        $display("%0t: reply_byte mismatch: expected %02h, actual %02h",
                 $time, due.value, value);
        errors++;
      end
      if (last !== due.last) begin
        $display("%0t: reply_last mismatch: expected %0b, actual %0b",
                 $time, due.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   reply_stall_pct;
  int   hold_left;
  bit   hold_done;
  int   cycle_count;

  reply_checker board;

  lsrd_cmd_if   cmd_ch ();
  lsrd_reply_if reply_ch ();

  line_sensor_ring_direction_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .reply (reply_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      board.check_reply(reply_ch.reply_byte, reply_ch.reply_last);
    end
  end

  initial begin
    reply_ch.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !hold_done && board.transfers_in >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        reply_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        reply_ch.ready = 1'b0;
        hold_left--;
      end else begin
        reply_ch.ready = ($urandom_range(99) >= reply_stall_pct);
      end
    end
  end

  task automatic drive_item(input logic op, input logic [LEVEL_W-1:0] levels,
                            input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid          = 1'b1;
    cmd_ch.opcode         = op;
    cmd_ch.sensor_levels  = levels;
    cmd_ch.command_first  = first;
    cmd_ch.command_second = second;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_transfer(op, levels, first, second);
  endtask

  task automatic send_sample(input logic [LEVEL_W-1:0] levels);
    drive_item(OPCODE_SAMPLE, levels, BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic send_command(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    drive_item(OPCODE_COMMAND, LEVEL_W'($urandom), first, second);
  endtask

  task automatic run_random(input int item_count);
    int                 counted;
    int                 pick;
    logic [LEVEL_W-1:0] levels;
    logic [BYTE_W-1:0]  first;
    logic [BYTE_W-1:0]  second;
    counted = 0;
    while (counted < item_count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          levels = LEVEL_W'($urandom);
        end else if (pick < 75) begin
          levels = '1;
          repeat ($urandom_range(1, 3)) levels[$urandom_range(SENSOR_COUNT - 1)] = 1'b0;
        end else if (pick < 88) begin
          levels = '0;
          repeat ($urandom_range(1, 3)) levels[$urandom_range(SENSOR_COUNT - 1)] = 1'b1;
        end else if (pick < 95) begin
          levels = '1;
        end else begin
          levels = '0;
        end
        send_sample(levels);
        counted++;
      end else if (pick < 75) begin
        send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
        counted++;
      end else if (pick < 85) begin
        send_command(CMD_ID_FIRST, CMD_ID_SECOND);
        counted++;
      end else begin
        case ($urandom_range(2))
          0:       first = CMD_ID_FIRST;
          1:       first = CMD_DIR_FIRST;
          default: first = BYTE_W'($urandom);
        endcase
        case ($urandom_range(2))
          0:       second = CMD_ID_SECOND;
          1:       second = CMD_DIR_SECOND;
          default: second = BYTE_W'($urandom);
        endcase
        send_command(first, second);
        counted++;
      end
    end
  endtask

  initial begin
    board = new();
    cycle_count           = 0;
    send_idle_pct         = 0;
    reply_stall_pct       = 0;
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.opcode         = OPCODE_SAMPLE;
    cmd_ch.sensor_levels  = '0;
    cmd_ch.command_first  = '0;
    cmd_ch.command_second = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_command(CMD_ID_FIRST, CMD_ID_SECOND);
    send_sample('1);
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'(1 << 0));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'(1 << 9));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'((1 << 4) | (1 << 5)));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'(1 << 7));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'(1 << 13));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample(~LEVEL_W'((1 << 4) | (1 << 16) | (1 << 17)));
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_sample('0);
    send_command(CMD_DIR_FIRST, CMD_DIR_SECOND);
    send_command(CMD_ID_FIRST, CMD_DIR_SECOND);
    send_command(CMD_DIR_FIRST, CMD_ID_SECOND);
    send_command(8'h00, 8'h00);
    send_command(8'hFF, 8'hFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct   = 0;
          reply_stall_pct = 0;
        end
        1: begin
          send_idle_pct   = 64;
          reply_stall_pct = 0;
        end
        2: begin
          send_idle_pct   = 0;
          reply_stall_pct = 64;
        end
        default: begin
          send_idle_pct   = 22;
          reply_stall_pct = 22;
        end
      endcase
      run_random(PHASE_ITEMS);
    end

    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (board.bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
